// ----- rtl/sntp_client_sequencer_top_assert.svh -----
// ----------------------------------------------------------------------------
// SNTP client sequencer - assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SNTP_CLIENT_SEQUENCER_TOP_ASSERT_SVH
`define SNTP_CLIENT_SEQUENCER_TOP_ASSERT_SVH

// Same-cycle implication, switched off while reset is asserted.
`define SCS_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is asserted.
`define SCS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/sntp_cs_pkg.sv -----
// ----------------------------------------------------------------------------
// SNTP client sequencer - package
// Item types, codes and constants shared by the sequencer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sntp_cs_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 40;
    localparam int TIMEOUT_W  = 40;

    typedef enum logic [2:0] {
        OP_TICK           = 3'd0,
        OP_LOOKUP_PENDING = 3'd1,
        OP_LOOKUP_FOUND   = 3'd2,
        OP_LOOKUP_FAILED  = 3'd3,
        OP_RESPONSE       = 3'd4
    } opcode_t;

    typedef enum logic [1:0] {
        ACT_NONE          = 2'd0,
        ACT_START_LOOKUP  = 2'd1,
        ACT_CLOSE_SOCKET  = 2'd2,
        ACT_UPDATE_ANCHOR = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ERR_NONE           = 3'd0,
        ERR_LOOKUP_TIMEOUT = 3'd1,
        ERR_REPLY_TIMEOUT  = 3'd2,
        ERR_LOOKUP_FAILED  = 3'd3,
        ERR_SEND_FAILED    = 3'd4,
        ERR_SHORT_REPLY    = 3'd5,
        ERR_ZERO_TIMESTAMP = 3'd6
    } error_t;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_RESOLVING = 3'd1,
        PH_WAITING   = 3'd2,
        PH_FAILED    = 3'd3,
        PH_DONE      = 3'd4
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE         = 3'd0,
        REG_LOOKUP_TIMEOUT = 3'd1,
        REG_REPLY_TIMEOUT  = 3'd2,
        REG_RETRY_WAIT     = 3'd3,
        REG_RESYNC_WAIT    = 3'd4
    } cfg_index_t;

    localparam logic [TIMEOUT_W-1:0] RST_LOOKUP_TIMEOUT = 40'd5_000_000;
    localparam logic [TIMEOUT_W-1:0] RST_REPLY_TIMEOUT  = 40'd5_000_000;
    localparam logic [TIMEOUT_W-1:0] RST_RETRY_WAIT     = 40'd30_000_000;
    localparam logic [TIMEOUT_W-1:0] RST_RESYNC_WAIT    = 40'd3_600_000_000;

    localparam logic [15:0] MIN_REPLY_BYTES   = 16'd48;
    localparam logic [29:0] NS_PER_S          = 30'd1_000_000_000;
    // seconds from the NTP epoch (1900) to the Unix epoch (1970)
    localparam logic [32:0] NTP_UNIX_OFFSET_S = 33'd2_208_988_800;
    // largest round trip whose product with 500 still fits 64 bits
    localparam logic [63:0] RTT_SAT_LIMIT     = 64'd36_893_488_147_419_103;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [63:0] now_us;
        logic        ntp_is_source;
        logic        send_ok;
        logic [15:0] reply_length;
        logic [31:0] tx_seconds;
        logic [31:0] tx_fraction;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [2:0]  error_code;
        logic [2:0]  phase;
        logic [63:0] anchor_utc_ns;
        logic [63:0] anchor_time_us;
    } out_item_t;

    typedef struct packed {
        logic                  wr_en;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

    // decided outcome of one event, carried alongside the anchor arithmetic
    typedef struct packed {
        action_t action;
        error_t  error_code;
        phase_t  phase;
        logic    anchor;
    } tag_t;

    typedef struct packed {
        tag_t        tag;
        logic [63:0] now_us;
        logic [63:0] sent_us;
        logic [31:0] tx_seconds;
        logic [31:0] tx_fraction;
    } job_t;

endpackage

`default_nettype wire

// ----- rtl/sntp_cs_front.sv -----
// ----------------------------------------------------------------------------
// SNTP client sequencer - front end
// Holds the registers and the phase state, classifies each event and
// pushes a job describing its outcome into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sntp_cs_front import sntp_cs_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire cfg_wr_t  cfg_wr,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_item_t s_data,
    input  wire logic     q_ready,
    output logic          q_push,
    output job_t          q_job
);

    logic                 enable_reg;
    logic [TIMEOUT_W-1:0] lookup_timeout_reg;
    logic [TIMEOUT_W-1:0] reply_timeout_reg;
    logic [TIMEOUT_W-1:0] retry_wait_reg;
    logic [TIMEOUT_W-1:0] resync_wait_reg;

    phase_t      phase_reg,   phase_next;
    logic [63:0] entered_reg, entered_next;
    logic [63:0] sent_reg,    sent_next;

    logic                 accept;
    logic [63:0]          elapsed;
    logic [TIMEOUT_W-1:0] limit;
    logic                 expired;
    tag_t                 tag;

    assign s_ready = q_ready;
    assign accept  = s_valid && q_ready;
    assign q_push  = accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg         <= 1'b0;
            lookup_timeout_reg <= RST_LOOKUP_TIMEOUT;
            reply_timeout_reg  <= RST_REPLY_TIMEOUT;
            retry_wait_reg     <= RST_RETRY_WAIT;
            resync_wait_reg    <= RST_RESYNC_WAIT;
        end else if (cfg_wr.wr_en) begin
            unique case (cfg_wr.index)
                REG_ENABLE:         enable_reg         <= cfg_wr.data[0];
                REG_LOOKUP_TIMEOUT: lookup_timeout_reg <= cfg_wr.data[TIMEOUT_W-1:0];
                REG_REPLY_TIMEOUT:  reply_timeout_reg  <= cfg_wr.data[TIMEOUT_W-1:0];
                REG_RETRY_WAIT:     retry_wait_reg     <= cfg_wr.data[TIMEOUT_W-1:0];
                REG_RESYNC_WAIT:    resync_wait_reg    <= cfg_wr.data[TIMEOUT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            entered_reg <= '0;
            sent_reg    <= '0;
        end else begin
            phase_reg   <= phase_next;
            entered_reg <= entered_next;
            sent_reg    <= sent_next;
        end
    end

    // one timer compare serves every timed phase
    assign elapsed = s_data.now_us - entered_reg;

    always_comb begin
        unique case (phase_reg)
            PH_RESOLVING: limit = lookup_timeout_reg;
            PH_WAITING:   limit = reply_timeout_reg;
            PH_FAILED:    limit = retry_wait_reg;
            PH_DONE:      limit = resync_wait_reg;
            PH_IDLE:      limit = '0;
            default:      limit = '0;
        endcase
    end

    assign expired = elapsed >= {24'd0, limit};

    always_comb begin
        phase_next     = phase_reg;
        entered_next   = entered_reg;
        sent_next      = sent_reg;
        tag.action     = ACT_NONE;
        tag.error_code = ERR_NONE;
        tag.anchor     = 1'b0;

        if (accept) begin
            unique case (s_data.opcode)
                OP_TICK: begin
                    if (enable_reg) begin
                        unique case (phase_reg)
                            PH_IDLE: tag.action = ACT_START_LOOKUP;
                            PH_RESOLVING: begin
                                if (expired) begin
                                    tag.error_code = ERR_LOOKUP_TIMEOUT;
                                    phase_next     = PH_FAILED;
                                    entered_next   = s_data.now_us;
                                end
                            end
                            PH_WAITING: begin
                                if (expired) begin
                                    tag.action     = ACT_CLOSE_SOCKET;
                                    tag.error_code = ERR_REPLY_TIMEOUT;
                                    phase_next     = PH_FAILED;
                                    entered_next   = s_data.now_us;
                                end
                            end
                            // back to idle keeps the entry time
                            PH_FAILED: begin
                                if (expired) phase_next = PH_IDLE;
                            end
                            PH_DONE: begin
                                if (s_data.ntp_is_source && expired) phase_next = PH_IDLE;
                            end
                            default: ;
                        endcase
                    end
                end
                OP_LOOKUP_PENDING: begin
                    phase_next   = PH_RESOLVING;
                    entered_next = s_data.now_us;
                end
                OP_LOOKUP_FOUND: begin
                    entered_next = s_data.now_us;
                    if (s_data.send_ok) begin
                        sent_next  = s_data.now_us;
                        phase_next = PH_WAITING;
                    end else begin
                        tag.action     = ACT_CLOSE_SOCKET;
                        tag.error_code = ERR_SEND_FAILED;
                        sent_next      = '0;
                        phase_next     = PH_FAILED;
                    end
                end
                OP_LOOKUP_FAILED: begin
                    tag.error_code = ERR_LOOKUP_FAILED;
                    phase_next     = PH_FAILED;
                    entered_next   = s_data.now_us;
                end
                OP_RESPONSE: begin
                    tag.action   = ACT_CLOSE_SOCKET;
                    entered_next = s_data.now_us;
                    if (s_data.reply_length < MIN_REPLY_BYTES) begin
                        tag.error_code = ERR_SHORT_REPLY;
                        phase_next     = PH_FAILED;
                    end else if (s_data.tx_seconds == '0) begin
                        tag.error_code = ERR_ZERO_TIMESTAMP;
                        phase_next     = PH_FAILED;
                    end else begin
                        tag.action = ACT_UPDATE_ANCHOR;
                        tag.anchor = 1'b1;
                        sent_next  = '0;
                        phase_next = PH_DONE;
                    end
                end
                default: ;
            endcase
        end

        tag.phase = phase_next;
    end

    // the job takes the send time from before this event clears it
    assign q_job.tag         = tag;
    assign q_job.now_us      = s_data.now_us;
    assign q_job.sent_us     = sent_reg;
    assign q_job.tx_seconds  = s_data.tx_seconds;
    assign q_job.tx_fraction = s_data.tx_fraction;

endmodule

`default_nettype wire

// ----- rtl/sntp_cs_queue.sv -----
// ----------------------------------------------------------------------------
// SNTP client sequencer - job queue
// Short first-in first-out queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module sntp_cs_queue import sntp_cs_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push_valid,
    output logic      push_ready,
    input  wire job_t push_data,
    output logic      pop_valid,
    input  wire logic pop_ready,
    output job_t      pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             do_push, do_pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = slots[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) slots[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

// ----- rtl/sntp_cs_back.sv -----
// ----------------------------------------------------------------------------
// SNTP client sequencer - back end
// Pipeline that turns queued jobs into results: NTP to Unix conversion,
// round-trip correction and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sntp_cs_back import sntp_cs_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic q_valid,
    output logic      q_pop,
    input  wire job_t q_job,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_item_t m_data
);

    // stage 1: era, epoch offset, round trip
    logic        v1_reg;
    tag_t        tag1_reg;
    logic [31:0] unix_s1_reg;
    logic [31:0] frac1_reg;
    logic [63:0] rtt1_reg;
    logic        corr1_reg;
    logic [63:0] sent1_reg;
    logic [63:0] now1_reg;

    // stage 2: products
    logic        v2_reg;
    tag_t        tag2_reg;
    logic [61:0] p_sec2_reg;
    logic [29:0] frac_ns2_reg;
    logic [63:0] one_way2_reg;
    logic        corr2_reg;
    logic [63:0] a_us2_reg;

    // stage 3: transmit time in ns
    logic        v3_reg;
    tag_t        tag3_reg;
    logic [63:0] t3_reg;
    logic [63:0] one_way3_reg;
    logic        corr3_reg;
    logic [63:0] a_us3_reg;

    logic      m_valid_reg;
    out_item_t m_data_reg;

    logic out_free, free3, free2, free1;
    logic adv3, adv2, adv1;

    logic [32:0] full_s;
    logic [31:0] unix_s;
    logic [63:0] rtt;
    logic        corr;
    logic [61:0] p_sec;
    logic [61:0] frac_prod;
    logic [63:0] one_way;
    logic [63:0] a_us;
    logic [63:0] t3;
    logic [64:0] corr_sum;
    logic [63:0] a_ns;

    // stall chain: a stage moves on when the one after it is free
    assign out_free = !m_valid_reg || m_ready;
    assign adv3     = v3_reg && out_free;
    assign free3    = !v3_reg || out_free;
    assign adv2     = v2_reg && free3;
    assign free2    = !v2_reg || free3;
    assign adv1     = v1_reg && free2;
    assign free1    = !v1_reg || free2;
    assign q_pop    = q_valid && free1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            v1_reg      <= q_pop || (v1_reg && !free2);
            v2_reg      <= adv1 || (v2_reg && !free3);
            v3_reg      <= adv2 || (v3_reg && !out_free);
            m_valid_reg <= adv3 || (m_valid_reg && !m_ready);
        end
    end

    // seconds with bit 31 clear belong to the 2036 era
    assign full_s = {~q_job.tx_seconds[31], q_job.tx_seconds};
    assign unix_s = (full_s > NTP_UNIX_OFFSET_S) ? 32'(full_s - NTP_UNIX_OFFSET_S) : '0;
    assign rtt    = q_job.now_us - q_job.sent_us;
    assign corr   = (q_job.sent_us != '0) && (q_job.now_us >= q_job.sent_us);

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            tag1_reg    <= q_job.tag;
            unix_s1_reg <= unix_s;
            frac1_reg   <= q_job.tx_fraction;
            rtt1_reg    <= rtt;
            corr1_reg   <= corr;
            sent1_reg   <= q_job.sent_us;
            now1_reg    <= q_job.now_us;
        end
    end

    assign p_sec     = 62'(unix_s1_reg) * 62'(NS_PER_S);
    assign frac_prod = 62'(frac1_reg) * 62'(NS_PER_S);
    // rtt * 500 as shift and subtract, saturated
    assign one_way   = (rtt1_reg > RTT_SAT_LIMIT) ? '1 :
                       (rtt1_reg << 9) - (rtt1_reg << 3) - (rtt1_reg << 2);
    assign a_us      = corr1_reg ? sent1_reg + {1'b0, rtt1_reg[63:1]} : now1_reg;

    always_ff @(posedge aclk) begin
        if (adv1) begin
            tag2_reg     <= tag1_reg;
            p_sec2_reg   <= p_sec;
            frac_ns2_reg <= frac_prod[61:32];
            one_way2_reg <= one_way;
            corr2_reg    <= corr1_reg;
            a_us2_reg    <= a_us;
        end
    end

    assign t3 = {2'b00, p_sec2_reg} + {34'd0, frac_ns2_reg};

    always_ff @(posedge aclk) begin
        if (adv2) begin
            tag3_reg     <= tag2_reg;
            t3_reg       <= t3;
            one_way3_reg <= one_way2_reg;
            corr3_reg    <= corr2_reg;
            a_us3_reg    <= a_us2_reg;
        end
    end

    assign corr_sum = {1'b0, t3_reg} + {1'b0, one_way3_reg};
    assign a_ns     = corr3_reg ? (corr_sum[64] ? '1 : corr_sum[63:0]) : t3_reg;

    always_ff @(posedge aclk) begin
        if (adv3) begin
            m_data_reg.action         <= tag3_reg.action;
            m_data_reg.error_code     <= tag3_reg.error_code;
            m_data_reg.phase          <= tag3_reg.phase;
            m_data_reg.anchor_utc_ns  <= tag3_reg.anchor ? a_ns : '0;
            m_data_reg.anchor_time_us <= tag3_reg.anchor ? a_us3_reg : '0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// ----- rtl/sntp_client_sequencer_top.sv -----
// ----------------------------------------------------------------------------
// SNTP client sequencer - top level
// Walks an SNTP query through its phases and turns server replies into
// clock anchors in Unix nanoseconds.
// ----------------------------------------------------------------------------
//   channel   direction  handshake              payload
//   s_        in         s_valid / s_ready      in_item_t  (event and time)
//   m_        out        m_valid / m_ready      out_item_t (action, anchor)
//   cfg_      in         cfg_wr_en only         cfg_index, cfg_data
//
// One event per cycle sustained while the queue has room; the phase and timer
// update is combinational in the front end (elapsed subtract, one timeout
// compare). Results pass the queue, back-end stage regs and output register.
// Reset is synchronous on aresetn low; no clearing pass follows it.
// A stalled m_ fills the back-end pipeline and then the queue; s_ready
// drops only when the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sntp_client_sequencer_top_assert.svh"

module sntp_client_sequencer_top import sntp_cs_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_item_t              s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_item_t                  m_data
);

    cfg_wr_t cfg_wr;
    logic    q_push;
    logic    q_ready;
    job_t    q_push_job;
    logic    q_valid;
    logic    q_pop;
    job_t    q_head_job;

    assign cfg_wr.wr_en = cfg_wr_en;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.data  = cfg_data;

    sntp_cs_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg_wr  (cfg_wr),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_ready (q_ready),
        .q_push  (q_push),
        .q_job   (q_push_job)
    );

    sntp_cs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (q_push),
        .push_ready (q_ready),
        .push_data  (q_push_job),
        .pop_valid  (q_valid),
        .pop_ready  (q_pop),
        .pop_data   (q_head_job)
    );

    sntp_cs_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_job   (q_head_job),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // an accepted event always leaves at least one job queued
    `SCS_ASSERT_NEXT(a_transfer_fills_queue, aclk, aresetn, s_valid && s_ready, q_valid, "event transfer left the job queue empty")
    `SCS_ASSERT_IMPL(a_anchor_only_in_done, aclk, aresetn, m_valid && (m_data.action == ACT_UPDATE_ANCHOR), m_data.phase == PH_DONE, "anchor update outside phase done")
    `SCS_ASSERT_IMPL(a_anchor_zero_otherwise, aclk, aresetn, m_valid && (m_data.action != ACT_UPDATE_ANCHOR), (m_data.anchor_utc_ns == '0) && (m_data.anchor_time_us == '0), "anchor fields set without anchor update")

endmodule

`default_nettype wire

// ----- test/sntp_client_sequencer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SNTP client sequencer - testbench
// Feeds events through the s_ channel, from a short scripted walk of every
// phase, error and anchor corner and then long runs of host-like sessions
// mixed with noise, under several register settings. Every result on m_ is
// compared field by field with a scripted value or a cycle-free model here.
// ----------------------------------------------------------------------------
module testbench;
    import sntp_cs_pkg::*;

    localparam logic [2:0]  OP_RESERVED_TOP = 3'd7;
    localparam logic [39:0] TIMER_MAX       = 40'hFF_FFFF_FFFF;
    localparam logic [63:0] TIME_MAX        = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [15:0] REPLY_MIN_BYTES = 16'd48;
    localparam logic [63:0] NS_IN_S         = 64'd1_000_000_000;
    localparam logic [63:0] EPOCH_GAP_S     = 64'd2_208_988_800;
    localparam logic [63:0] RTT_CAP         = TIME_MAX / 64'd500;

    typedef struct {
        bit          is_write;
        cfg_index_t  reg_sel;
        logic [39:0] reg_val;
        in_item_t    ev;
        bit          typed;
        out_item_t   want;
    } script_row_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_data;

    // model state and registers
    phase_t      seq_phase      = PH_IDLE;
    logic [63:0] seq_entered_us = '0;
    logic [63:0] seq_sent_us    = '0;
    bit          cfg_enable     = 1'b0;
    logic [39:0] cfg_lookup_us  = 40'd5_000_000;
    logic [39:0] cfg_reply_us   = 40'd5_000_000;
    logic [39:0] cfg_retry_us   = 40'd30_000_000;
    logic [39:0] cfg_resync_us  = 40'd3_600_000_000;

    out_item_t   expected_results[$];
    script_row_t script[$];
    out_item_t   head_result;
    logic [63:0] clock_us      = 64'd1000;
    bit          quiet_tail    = 1'b0;
    int unsigned stall_left    = 0;
    int unsigned faults        = 0;
    int unsigned results_seen  = 0;
    int unsigned anchors_seen  = 0;
    int unsigned errors_seen   = 0;
    int unsigned settings_used = 0;

    sntp_client_sequencer_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic void move_to(phase_t next, logic [63:0] at_us);
        seq_phase      = next;
        seq_entered_us = at_us;
    endfunction

    function automatic out_item_t advance_sequencer(in_item_t ev);
        out_item_t   r;
        logic [63:0] elapsed, full_s, unix_s, frac_ns, t3, rtt, one_way, total;
        r = '0;
        elapsed = ev.now_us - seq_entered_us;
        case (ev.opcode)
            OP_TICK: begin
                if (cfg_enable) begin
                    case (seq_phase)
                        PH_IDLE: r.action = ACT_START_LOOKUP;
                        PH_RESOLVING: begin
                            if (elapsed >= {24'd0, cfg_lookup_us}) begin
                                r.error_code = ERR_LOOKUP_TIMEOUT;
                                move_to(PH_FAILED, ev.now_us);
                            end
                        end
                        PH_WAITING: begin
                            if (elapsed >= {24'd0, cfg_reply_us}) begin
                                r.action     = ACT_CLOSE_SOCKET;
                                r.error_code = ERR_REPLY_TIMEOUT;
                                move_to(PH_FAILED, ev.now_us);
                            end
                        end
                        // the entry time is kept on the way back to idle
                        PH_FAILED: begin
                            if (elapsed >= {24'd0, cfg_retry_us}) seq_phase = PH_IDLE;
                        end
                        PH_DONE: begin
                            if (ev.ntp_is_source && elapsed >= {24'd0, cfg_resync_us})
                                seq_phase = PH_IDLE;
                        end
                        default: ;
                    endcase
                end
            end
            OP_LOOKUP_PENDING: move_to(PH_RESOLVING, ev.now_us);
            OP_LOOKUP_FOUND: begin
                if (ev.send_ok) begin
                    seq_sent_us = ev.now_us;
                    move_to(PH_WAITING, ev.now_us);
                end else begin
                    r.action     = ACT_CLOSE_SOCKET;
                    r.error_code = ERR_SEND_FAILED;
                    seq_sent_us  = '0;
                    move_to(PH_FAILED, ev.now_us);
                end
            end
            OP_LOOKUP_FAILED: begin
                r.error_code = ERR_LOOKUP_FAILED;
                move_to(PH_FAILED, ev.now_us);
            end
            OP_RESPONSE: begin
                r.action = ACT_CLOSE_SOCKET;
                if (ev.reply_length < REPLY_MIN_BYTES) begin
                    r.error_code = ERR_SHORT_REPLY;
                    move_to(PH_FAILED, ev.now_us);
                end else if (ev.tx_seconds == 32'd0) begin
                    r.error_code = ERR_ZERO_TIMESTAMP;
                    move_to(PH_FAILED, ev.now_us);
                end else begin
                    full_s = {32'd0, ev.tx_seconds};
                    // top bit clear means the era starting in 2036
                    if (!ev.tx_seconds[31]) full_s = full_s + 64'h1_0000_0000;
                    unix_s  = (full_s > EPOCH_GAP_S) ? full_s - EPOCH_GAP_S : 64'd0;
                    frac_ns = ({32'd0, ev.tx_fraction} * NS_IN_S) >> 32;
                    t3      = unix_s * NS_IN_S + frac_ns;
                    r.anchor_utc_ns  = t3;
                    r.anchor_time_us = ev.now_us;
                    // shift the anchor to the midpoint of the round trip
                    if (seq_sent_us != 0 && ev.now_us >= seq_sent_us) begin
                        rtt     = ev.now_us - seq_sent_us;
                        one_way = (rtt > RTT_CAP) ? TIME_MAX : rtt * 64'd500;
                        total   = t3 + one_way;
                        r.anchor_utc_ns  = (total < t3) ? TIME_MAX : total;
                        r.anchor_time_us = seq_sent_us + (rtt >> 1);
                    end
                    seq_sent_us = '0;
                    r.action    = ACT_UPDATE_ANCHOR;
                    move_to(PH_DONE, ev.now_us);
                end
            end
            default: ;
        endcase
        r.phase = seq_phase;
        return r;
    endfunction

    function automatic in_item_t ev_of(logic [2:0] op, logic [63:0] now, bit ntp, bit ok,
                                       logic [15:0] len, logic [31:0] secs,
                                       logic [31:0] frac);
        in_item_t e;
        e.opcode        = op;
        e.now_us        = now;
        e.ntp_is_source = ntp;
        e.send_ok       = ok;
        e.reply_length  = len;
        e.tx_seconds    = secs;
        e.tx_fraction   = frac;
        return e;
    endfunction

    function automatic out_item_t res(action_t act, error_t err, phase_t ph,
                                      logic [63:0] ns, logic [63:0] us);
        out_item_t r;
        r.action         = act;
        r.error_code     = err;
        r.phase          = ph;
        r.anchor_utc_ns  = ns;
        r.anchor_time_us = us;
        return r;
    endfunction

    function automatic void add_event(in_item_t e);
        script.push_back('{1'b0, REG_ENABLE, 40'd0, e, 1'b0, out_item_t'('0)});
    endfunction

    function automatic void add_checked(in_item_t e, out_item_t w);
        script.push_back('{1'b0, REG_ENABLE, 40'd0, e, 1'b1, w});
    endfunction

    function automatic void add_write(cfg_index_t sel, logic [39:0] value);
        script.push_back('{1'b1, sel, value, in_item_t'('0), 1'b0, out_item_t'('0)});
    endfunction

    function automatic logic [39:0] pick_timer(int unsigned setting_no);
        int unsigned mode;
        mode = (setting_no == 0) ? 2 : (setting_no == 1) ? 0 :
               (setting_no == 3) ? 1 : $urandom_range(0, 3);
        case (mode)
            0:       return 40'd0;
            1:       return TIMER_MAX;
            2:       return 40'($urandom_range(0, 3000));
            default: return {8'($urandom), 32'($urandom)};
        endcase
    endfunction

    // Mostly what a host would report next from the current phase, with noise.
    function automatic in_item_t next_event();
        in_item_t    ev;
        int unsigned roll;
        ev.opcode        = OP_TICK;
        ev.now_us        = {$urandom, $urandom};
        ev.ntp_is_source = 1'($urandom_range(0, 1));
        ev.send_ok       = 1'($urandom_range(0, 1));
        ev.reply_length  = 16'($urandom_range(0, 65535));
        ev.tx_seconds    = $urandom;
        ev.tx_fraction   = $urandom;
        roll = $urandom_range(0, 99);
        if (roll < 12) begin
            ev.opcode = 3'($urandom_range(0, 7));
            return ev;
        end
        if ($urandom_range(0, 19) == 0) clock_us = clock_us + 64'($urandom);
        else clock_us = clock_us + 64'($urandom_range(0, 2000));
        ev.now_us = clock_us;
        roll = $urandom_range(0, 99);
        case (seq_phase)
            PH_IDLE: ev.opcode = (roll < 45) ? OP_TICK : (roll < 70) ? OP_LOOKUP_PENDING :
                                 (roll < 95) ? OP_LOOKUP_FOUND : OP_LOOKUP_FAILED;
            PH_RESOLVING: ev.opcode = (roll < 40) ? OP_TICK :
                                      (roll < 85) ? OP_LOOKUP_FOUND : OP_LOOKUP_FAILED;
            PH_WAITING: ev.opcode = (roll < 40) ? OP_TICK : OP_RESPONSE;
            PH_FAILED: ev.opcode = (roll < 70) ? OP_TICK :
                                   (roll < 85) ? OP_LOOKUP_PENDING : OP_LOOKUP_FOUND;
            default: ev.opcode = (roll < 85) ? OP_TICK : OP_RESPONSE;
        endcase
        if (ev.opcode == OP_LOOKUP_FOUND) ev.send_ok = ($urandom_range(0, 9) != 0);
        if (ev.opcode == OP_RESPONSE) begin
            if ($urandom_range(0, 7) != 0) ev.reply_length = 16'($urandom_range(48, 65535));
            else ev.reply_length = 16'($urandom_range(0, 47));
            if ($urandom_range(0, 9) == 0) ev.tx_seconds = 32'd0;
        end
        return ev;
    endfunction

    task automatic send_event(in_item_t ev, bit typed, out_item_t want);
        out_item_t predicted;
        s_valid <= 1'b1;
        s_data  <= ev;
        do @(posedge aclk); while (!s_ready);
        predicted = advance_sequencer(ev);
        expected_results.push_back(typed ? want : predicted);
        // hold valid for the next event unless a gap is drawn
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        // let the pipeline settle before anything else
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_register(cfg_index_t sel, logic [39:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (sel)
            REG_ENABLE:         cfg_enable    = value[0];
            REG_LOOKUP_TIMEOUT: cfg_lookup_us = value;
            REG_REPLY_TIMEOUT:  cfg_reply_us  = value;
            REG_RETRY_WAIT:     cfg_retry_us  = value;
            REG_RESYNC_WAIT:    cfg_resync_us = value;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic report_fault(string what, out_item_t w, out_item_t g);
        faults++;
        if (faults <= 10) begin
            $display("[%0t] %s: expected act=%0d err=%0d ph=%0d ns=%h us=%h", $realtime, what,
                     w.action, w.error_code, w.phase, w.anchor_utc_ns, w.anchor_time_us);
            $display("      got act=%0d err=%0d ph=%0d ns=%h us=%h",
                     g.action, g.error_code, g.phase, g.anchor_utc_ns, g.anchor_time_us);
        end
    endtask

    // result side: check each transfer and stall m_ready in bursts
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_fault("result with nothing expected", out_item_t'('0), m_data);
            end else begin
                head_result = expected_results.pop_front();
                results_seen++;
                if (head_result.action == ACT_UPDATE_ANCHOR) anchors_seen++;
                if (head_result.error_code != ERR_NONE) errors_seen++;
                if (m_data.action !== head_result.action ||
                    m_data.error_code !== head_result.error_code ||
                    m_data.phase !== head_result.phase ||
                    m_data.anchor_utc_ns !== head_result.anchor_utc_ns ||
                    m_data.anchor_time_us !== head_result.anchor_time_us)
                    report_fault("result mismatch", head_result, m_data);
            end
        end
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 15);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin
        #10ms;
        $display("FAIL sntp_client_sequencer_top");
        $finish;
    end

    initial begin : stimulus
        in_item_t    ev;
        int unsigned setting_sent;
        int unsigned directed_sent;
        int unsigned random_sent;
        directed_sent = 0;
        random_sent   = 0;

        // registers still at reset, block disabled
        add_checked(ev_of(OP_TICK, 64'd0, 1, 1, 16'd0, 32'd0, 32'd0),
                    res(ACT_NONE, ERR_NONE, PH_IDLE, 64'd0, 64'd0));
        add_checked(ev_of(OP_RESERVED_TOP, TIME_MAX, 1, 1, 16'hFFFF, '1, '1),
                    res(ACT_NONE, ERR_NONE, PH_IDLE, 64'd0, 64'd0));
        add_checked(ev_of(OP_LOOKUP_PENDING, 64'd10, 0, 0, 16'd0, 32'd0, 32'd0),
                    res(ACT_NONE, ERR_NONE, PH_RESOLVING, 64'd0, 64'd0));
        add_write(REG_ENABLE, 40'd1);
        add_write(REG_LOOKUP_TIMEOUT, 40'd0);
        add_write(REG_REPLY_TIMEOUT, TIMER_MAX);
        add_write(REG_RETRY_WAIT, 40'd0);
        add_write(REG_RESYNC_WAIT, TIMER_MAX);
        add_checked(ev_of(OP_TICK, 64'd20, 0, 0, 16'd0, 32'd0, 32'd0),
                    res(ACT_NONE, ERR_LOOKUP_TIMEOUT, PH_FAILED, 64'd0, 64'd0));
        add_checked(ev_of(OP_TICK, 64'd20, 1, 0, 16'd0, 32'd0, 32'd0),
                    res(ACT_NONE, ERR_NONE, PH_IDLE, 64'd0, 64'd0));
        add_checked(ev_of(OP_TICK, 64'd30, 0, 1, 16'd0, 32'd0, 32'd0),
                    res(ACT_START_LOOKUP, ERR_NONE, PH_IDLE, 64'd0, 64'd0));
        add_checked(ev_of(OP_LOOKUP_FAILED, 64'd40, 0, 1, 16'd0, 32'd0, 32'd0),
                    res(ACT_NONE, ERR_LOOKUP_FAILED, PH_FAILED, 64'd0, 64'd0));
        add_checked(ev_of(OP_LOOKUP_FOUND, 64'd50, 1, 0, 16'd0, 32'd0, 32'd0),
                    res(ACT_CLOSE_SOCKET, ERR_SEND_FAILED, PH_FAILED, 64'd0, 64'd0));
        add_checked(ev_of(OP_LOOKUP_FOUND, 64'd1000, 0, 1, 16'd0, 32'd0, 32'd0),
                    res(ACT_NONE, ERR_NONE, PH_WAITING, 64'd0, 64'd0));
        add_event(ev_of(OP_TICK, 64'd2000, 1, 1, 16'd0, 32'd0, 32'd0));
        add_checked(ev_of(OP_RESPONSE, 64'd2100, 0, 0, 16'd47, 32'hE000_0000, 32'd1),
                    res(ACT_CLOSE_SOCKET, ERR_SHORT_REPLY, PH_FAILED, 64'd0, 64'd0));
        add_checked(ev_of(OP_LOOKUP_FOUND, 64'd3000, 0, 1, 16'd0, 32'd0, 32'd0),
                    res(ACT_NONE, ERR_NONE, PH_WAITING, 64'd0, 64'd0));
        add_checked(ev_of(OP_RESPONSE, 64'd3100, 0, 0, 16'd48, 32'd0, 32'hFFFF_FFFF),
                    res(ACT_CLOSE_SOCKET, ERR_ZERO_TIMESTAMP, PH_FAILED, 64'd0, 64'd0));
        add_checked(ev_of(OP_LOOKUP_FOUND, 64'd4000, 0, 1, 16'd0, 32'd0, 32'd0),
                    res(ACT_NONE, ERR_NONE, PH_WAITING, 64'd0, 64'd0));
        add_event(ev_of(OP_RESPONSE, 64'd4_001_234, 0, 0, 16'hFFFF, '1, '1));
        add_event(ev_of(OP_TICK, 64'd10_000_000, 0, 0, 16'd0, 32'd0, 32'd0));
        add_event(ev_of(OP_TICK, TIME_MAX, 1, 0, 16'd0, 32'd0, 32'd0));
        // before 1970: saturates to zero, no request outstanding
        add_checked(ev_of(OP_RESPONSE, 64'd77, 0, 0, 16'd48, 32'h8000_0000, 32'd0),
                    res(ACT_UPDATE_ANCHOR, ERR_NONE, PH_DONE, 64'd0, 64'd77));
        add_event(ev_of(OP_RESPONSE, 64'd5, 1, 1, 16'd100, 32'd1, 32'h8000_0000));
        add_event(ev_of(OP_LOOKUP_FOUND, 64'd1000, 0, 1, 16'd0, 32'd0, 32'd0));
        add_event(ev_of(OP_RESPONSE, 64'd999, 0, 0, 16'd100, 32'hE000_0000, 32'd1));
        add_event(ev_of(OP_LOOKUP_FOUND, 64'd1, 0, 1, 16'd0, 32'd0, 32'd0));
        add_event(ev_of(OP_RESPONSE, TIME_MAX, 0, 0, 16'd48, 32'h7FFF_FFFF, '1));
        add_write(REG_REPLY_TIMEOUT, 40'd0);
        add_checked(ev_of(OP_LOOKUP_FOUND, 64'd10, 0, 1, 16'd0, 32'd0, 32'd0),
                    res(ACT_NONE, ERR_NONE, PH_WAITING, 64'd0, 64'd0));
        add_checked(ev_of(OP_TICK, 64'd10, 0, 0, 16'd0, 32'd0, 32'd0),
                    res(ACT_CLOSE_SOCKET, ERR_REPLY_TIMEOUT, PH_FAILED, 64'd0, 64'd0));

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        settings_used = 1;
        foreach (script[i]) begin
            if (script[i].is_write) begin
                drain_results();
                write_register(script[i].reg_sel, script[i].reg_val);
            end else begin
                send_event(script[i].ev, script[i].typed, script[i].want);
                directed_sent++;
            end
        end

        for (int unsigned setting_no = 0; setting_no < 7; setting_no++) begin
            drain_results();
            settings_used++;
            write_register(REG_ENABLE, (setting_no == 2) ? 40'd0 : 40'd1);
            write_register(REG_LOOKUP_TIMEOUT, pick_timer(setting_no));
            write_register(REG_REPLY_TIMEOUT, pick_timer(setting_no));
            write_register(REG_RETRY_WAIT, pick_timer(setting_no));
            write_register(REG_RESYNC_WAIT, pick_timer(setting_no));
            setting_sent = 0;
            while (setting_sent < 246) begin
                if (setting_no == 6 && setting_sent == 60) quiet_tail = 1'b1;
                if (!quiet_tail && $urandom_range(0, 199) == 0) drain_results();
                ev = next_event();
                send_event(ev, 1'b0, out_item_t'('0));
                setting_sent++;
                random_sent++;
            end
        end

        drain_results();
        $display("Sent %0d events (%0d scripted, %0d random) over %0d register settings",
                 directed_sent + random_sent, directed_sent, random_sent, settings_used);
        $display("Checked %0d results: %0d clock anchors, %0d error outcomes, %0d faults",
                 results_seen, anchors_seen, errors_seen, faults);
        if (faults == 0) begin
            $display("PASS sntp_client_sequencer_top");
        end else begin
            $display("FAIL sntp_client_sequencer_top");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/sntp_cs_pkg.sv
rtl/sntp_cs_front.sv
rtl/sntp_cs_queue.sv
rtl/sntp_cs_back.sv
rtl/sntp_client_sequencer_top.sv
test/sntp_client_sequencer_tb.sv
